// File: hdl/pidl_pkg.sv
package pidl_pkg;

   // Store geometry
   localparam int DEPTH = 64;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Fixed field widths
   localparam int POS_W = 7;
   localparam int CAP_W = 7;
   localparam int LEN_W = 7;
   localparam int VAL_W = 32;
   localparam int ST_W  = 2;
   localparam int RQ_W  = 2;

   // Width that holds both a position and a count
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Request codes
   localparam logic [RQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [RQ_W-1:0] REQ_APPEND = 2'd1;
   localparam logic [RQ_W-1:0] REQ_REMOVE = 2'd2;
   localparam logic [RQ_W-1:0] REQ_READ   = 2'd3;

   // Status codes
   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

   // Cell commands
   localparam logic [1:0] CMD_HOLD   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   // Configuration register map
   localparam int          CSR_ADDR_W   = 3;
   localparam int          CSR_DATA_W   = 32;
   localparam logic [0:0]  CSR_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef struct packed {
      logic [RQ_W-1:0]         req_type;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic signed [VAL_W-1:0] read_value;
      logic [LEN_W-1:0]        length;
      logic                    full_res;
   } rsp_item_type;

   // Broadcast to every cell of the row
   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] pos;
      logic [VAL_W-1:0] value;
   } cell_cmd_type;

endpackage

// File: hdl/pidl_cell.sv
module pidl_cell (
   input  logic                           clock,
   input  logic [pidl_pkg::IDX_W-1:0]     cell_index,
   input  pidl_pkg::cell_cmd_type         cmd,
   input  logic [pidl_pkg::VAL_W-1:0]     lower_data,
   input  logic [pidl_pkg::VAL_W-1:0]     upper_data,
   output logic [pidl_pkg::VAL_W-1:0]     entry,
   output logic [pidl_pkg::VAL_W-1:0]     tap_data
);

   logic [pidl_pkg::VAL_W-1:0] entry_ff;
   logic [pidl_pkg::VAL_W-1:0] entry_in;

   // Pick next entry: shift up, load, shift down or hold
   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         pidl_pkg::CMD_INSERT: begin
            if (cell_index > cmd.pos) begin
               entry_in = lower_data;
            end else if (cell_index == cmd.pos) begin
               entry_in = cmd.value;
            end
         end
         pidl_pkg::CMD_REMOVE: begin
            if (cell_index >= cmd.pos) begin
               entry_in = upper_data;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry    = entry_ff;
   // Drive the read bus only from the addressed cell
   assign tap_data = (cell_index == cmd.pos) ? entry_ff : '0;

endmodule

// File: hdl/positional_insert_delete_list.sv
// Bounded ordered list of signed 32-bit values held in a row of DEPTH cells, each
// cell one entry. A transaction inserts at a position, appends, removes at a position
// or reads at a position; insert and remove move every later entry one cell at
// once, and a new transaction is taken every cycle while the result register is
// free or being drained. The result appears in the cycle after acceptance.
// Capacity comes from the register at address 0 (reset 64) and saturates at
// DEPTH. Entries beyond the current length are not cleared and are never returned.
module positional_insert_delete_list (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  pidl_pkg::req_item_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output pidl_pkg::rsp_item_type            rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pidl_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pidl_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pidl_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int DEPTH = pidl_pkg::DEPTH;
   localparam int CMP_W = pidl_pkg::CMP_W;
   localparam int VAL_W = pidl_pkg::VAL_W;

   logic [pidl_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [pidl_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   pidl_pkg::rsp_item_type     rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic [CMP_W-1:0]           cnt_ext, pos_ext, cap_ext, cap_eff, sel_pos, cnt_next;
   logic                       is_ins, is_rem, is_read, full_now;
   logic [pidl_pkg::ST_W-1:0]  status;
   pidl_pkg::cell_cmd_type     cmd;
   logic [VAL_W-1:0]           entry [DEPTH];
   logic [VAL_W-1:0]           tap   [DEPTH];
   logic [VAL_W-1:0]           rd_bus;

   // Configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == pidl_pkg::CSR_CAPACITY)
                   ? {{(pidl_pkg::CSR_DATA_W - pidl_pkg::CAP_W){1'b0}}, cap_ff} : '0;
   assign cap_in = (psel && penable && pwrite && (paddr[2] == pidl_pkg::CSR_CAPACITY))
                   ? pwdata[pidl_pkg::CAP_W-1:0] : cap_ff;

   // Handshake: hold input during reset or while the result register is blocked
   assign req_stall = reset || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // Decode the transaction
   assign cnt_ext  = CMP_W'(cnt_ff);
   assign pos_ext  = CMP_W'(req_data.position);
   assign cap_ext  = CMP_W'(cap_ff);
   assign cap_eff  = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
   assign full_now = (cnt_ext >= cap_eff);
   assign is_ins   = (req_data.req_type == pidl_pkg::REQ_INSERT) ||
                     (req_data.req_type == pidl_pkg::REQ_APPEND);
   assign is_rem   = (req_data.req_type == pidl_pkg::REQ_REMOVE);
   assign is_read  = (req_data.req_type == pidl_pkg::REQ_READ);
   assign sel_pos  = (req_data.req_type == pidl_pkg::REQ_APPEND) ? cnt_ext : pos_ext;

   always_comb begin
      status = pidl_pkg::ST_DONE;
      priority if (is_ins && full_now) begin
         status = pidl_pkg::ST_FULL;
      end else if (is_ins && (sel_pos > cnt_ext)) begin
         status = pidl_pkg::ST_RANGE;
      end else if (!is_ins && (sel_pos >= cnt_ext)) begin
         status = pidl_pkg::ST_RANGE;
      end
   end

   // Broadcast command to the cell row
   always_comb begin
      cmd.op    = pidl_pkg::CMD_HOLD;
      cmd.pos   = sel_pos[pidl_pkg::IDX_W-1:0];
      cmd.value = req_data.value;
      if (accept && (status == pidl_pkg::ST_DONE)) begin
         if (is_ins) begin
            cmd.op = pidl_pkg::CMD_INSERT;
         end else if (is_rem) begin
            cmd.op = pidl_pkg::CMD_REMOVE;
         end
      end
   end

   // Cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VAL_W-1:0] lower, upper;
      if (i == 0) begin : g_first
         assign lower = '0;
      end else begin : g_lower
         assign lower = entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign upper = '0;
      end else begin : g_upper
         assign upper = entry[i+1];
      end
      pidl_cell u_cell (
         .clock      (clock),
         .cell_index (pidl_pkg::IDX_W'(i)),
         .cmd        (cmd),
         .lower_data (lower),
         .upper_data (upper),
         .entry      (entry[i]),
         .tap_data   (tap[i])
      );
   end

   // Collect the addressed entry
   always_comb begin
      rd_bus = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_bus = rd_bus | tap[i];
      end
   end

   // Advance the count
   always_comb begin
      cnt_next = cnt_ext;
      if (cmd.op == pidl_pkg::CMD_INSERT) begin
         cnt_next = cnt_ext + CMP_W'(1);
      end else if (cmd.op == pidl_pkg::CMD_REMOVE) begin
         cnt_next = cnt_ext - CMP_W'(1);
      end
   end
   assign cnt_in = pidl_pkg::CNT_W'(cnt_next);

   // Build the result
   always_comb begin
      rsp_data_in.status     = status;
      rsp_data_in.read_value = (is_read && (status == pidl_pkg::ST_DONE)) ? rd_bus : '0;
      rsp_data_in.length     = pidl_pkg::LEN_W'(cnt_next);
      rsp_data_in.full_res   = (cnt_next >= cap_eff);
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= pidl_pkg::CAP_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hdl/pidl_check.sv
module pidl_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  pidl_pkg::req_item_type            req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  pidl_pkg::rsp_item_type            rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pidl_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pidl_pkg::CSR_DATA_W-1:0]   pwdata,
   input  logic [pidl_pkg::CSR_DATA_W-1:0]   prdata,
   input  logic                              pready
);

   // A blocked result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Every accepted transaction yields a result next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted transaction gave no result");

   // Input stalls only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with free result register");

   // A full refusal reports a full list
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == pidl_pkg::ST_FULL) |-> rsp_data.full_res)
      else $error("full refusal without full flag");

   // Length never exceeds the store
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pidl_pkg::CMP_W'(rsp_data.length) <= pidl_pkg::CMP_W'(pidl_pkg::DEPTH)))
      else $error("length beyond store depth");

endmodule

bind positional_insert_delete_list pidl_check u_pidl_check (.*);

// File: verif/tb_positional_insert_delete_list.sv
`timescale 1ns / 1ps

module tb_positional_insert_delete_list;

   localparam int LIMIT       = 200000;
   localparam int MAX_REPORTS = 10;
   localparam int PHASES      = 11;
   localparam int ANY_CAP     = -1;
   localparam logic [pidl_pkg::CSR_ADDR_W-1:0] CAPACITY_ADDR =
      pidl_pkg::CSR_ADDR_W'(4 * pidl_pkg::CSR_CAPACITY);

   typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;
   typedef enum logic {ROW_ITEM, ROW_CAPACITY} row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      pidl_pkg::req_item_type          item;
      logic                            known;
      pidl_pkg::rsp_item_type          result;
      logic [pidl_pkg::CAP_W-1:0]      capacity;
   } script_row_type;

   typedef struct packed {
      logic                   known;
      pidl_pkg::rsp_item_type result;
   } fixed_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pidl_pkg::req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pidl_pkg::rsp_item_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [pidl_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [pidl_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [pidl_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   // List contents and capacity as the block should hold them
   logic signed [pidl_pkg::VAL_W-1:0] list_cells [pidl_pkg::DEPTH];
   int                         list_len  = 0;
   logic [pidl_pkg::CAP_W-1:0] cap_value = pidl_pkg::CAP_RESET;

   pidl_pkg::rsp_item_type list_results_due [$];
   fixed_result_type       fixed_results [$];
   script_row_type         script [$];
   int                     errors = 0;
   logic                   calm   = 1'b0;
   int                     stall_left = 0;

   int      phase_cap [PHASES] = '{64, 64, 127, 5, 5, 0, 1, ANY_CAP, ANY_CAP, 64, 64};
   mix_type phase_mix [PHASES] = '{MIX_FILL, MIX_EVEN, MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_EVEN,
                                   MIX_EVEN, MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_EVEN};
   int      phase_len [PHASES] = '{90, 80, 60, 60, 80, 40, 50, 60, 80, 70, 80};

   positional_insert_delete_list uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one request to the list and return the result it produces
   function automatic pidl_pkg::rsp_item_type list_apply(pidl_pkg::req_item_type it);
      pidl_pkg::rsp_item_type r;
      int lim;
      int at;
      int i;
      r = '0;
      r.status = pidl_pkg::ST_DONE;
      lim = (int'(cap_value) > pidl_pkg::DEPTH) ? pidl_pkg::DEPTH : int'(cap_value);
      at = int'(it.position);
      case (it.req_type)
         pidl_pkg::REQ_INSERT, pidl_pkg::REQ_APPEND: begin
            if (it.req_type == pidl_pkg::REQ_APPEND) at = list_len;
            if (list_len >= lim) begin
               r.status = pidl_pkg::ST_FULL;
            end else if (at > list_len) begin
               r.status = pidl_pkg::ST_RANGE;
            end else begin
               for (i = list_len; i > at; i--) list_cells[i] = list_cells[i - 1];
               list_cells[at] = it.value;
               list_len++;
            end
         end
         pidl_pkg::REQ_REMOVE: begin
            if (at >= list_len) begin
               r.status = pidl_pkg::ST_RANGE;
            end else begin
               for (i = at; i + 1 < list_len; i++) list_cells[i] = list_cells[i + 1];
               list_len--;
            end
         end
         default: begin
            if (at >= list_len) r.status = pidl_pkg::ST_RANGE;
            else r.read_value = list_cells[at];
         end
      endcase
      r.length   = pidl_pkg::LEN_W'(list_len);
      r.full_res = (list_len >= lim);
      return r;
   endfunction

   // Random request shaped by the phase mix; positions mostly legal
   function automatic pidl_pkg::req_item_type pick_request(mix_type mix);
      pidl_pkg::req_item_type it;
      int grow;
      int shrink;
      int roll;
      it.value    = $urandom();
      it.position = pidl_pkg::POS_W'($urandom_range(127, 0));
      case (mix)
         MIX_FILL: begin
            grow = 80;
            shrink = 10;
         end
         MIX_DRAIN: begin
            grow = 10;
            shrink = 75;
         end
         default: begin
            grow = 40;
            shrink = 35;
         end
      endcase
      roll = $urandom_range(99, 0);
      if ($urandom_range(11, 0) == 0) begin
         // noise: any code at any position
         it.req_type = pidl_pkg::RQ_W'($urandom_range(3, 0));
      end else if (roll < grow) begin
         if (roll[0]) begin
            it.req_type = pidl_pkg::REQ_APPEND;
         end else begin
            it.req_type = pidl_pkg::REQ_INSERT;
            it.position = pidl_pkg::POS_W'($urandom_range(list_len, 0));
         end
      end else begin
         it.req_type = (roll < grow + shrink) ? pidl_pkg::REQ_REMOVE : pidl_pkg::REQ_READ;
         if (list_len > 0) it.position = pidl_pkg::POS_W'($urandom_range(list_len - 1, 0));
      end
      return it;
   endfunction

   function automatic void add_item(logic [pidl_pkg::RQ_W-1:0] kind, int pos,
                                    logic [pidl_pkg::VAL_W-1:0] val);
      script_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.item.req_type = kind;
      row.item.position = pidl_pkg::POS_W'(pos);
      row.item.value = val;
      script.push_back(row);
   endfunction

   function automatic void add_known(logic [pidl_pkg::RQ_W-1:0] kind, int pos,
                                     logic [pidl_pkg::VAL_W-1:0] val,
                                     logic [pidl_pkg::ST_W-1:0] st,
                                     logic [pidl_pkg::VAL_W-1:0] rd, int len,
                                     logic full);
      add_item(kind, pos, val);
      script[$].known = 1'b1;
      script[$].result.status = st;
      script[$].result.read_value = rd;
      script[$].result.length = pidl_pkg::LEN_W'(len);
      script[$].result.full_res = full;
   endfunction

   function automatic void add_capacity(int v);
      script_row_type row;
      row = '0;
      row.kind = ROW_CAPACITY;
      row.capacity = pidl_pkg::CAP_W'(v);
      script.push_back(row);
   endfunction

   // Check delivered results, predict accepted requests, track capacity writes
   always @(posedge clock) begin : watch
      pidl_pkg::rsp_item_type want;
      pidl_pkg::rsp_item_type model_out;
      fixed_result_type hint;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (list_results_due.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("unexpected result transaction at %0t: %p", $realtime, rsp_data);
            end else begin
               want = list_results_due.pop_front();
               if (rsp_data.status !== want.status || rsp_data.read_value !== want.read_value
                   || rsp_data.length !== want.length
                   || rsp_data.full_res !== want.full_res) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display(
                        "mismatch at %0t (exp/act): st %0d/%0d rd %0d/%0d len %0d/%0d full %0b/%0b",
                        $realtime, want.status, rsp_data.status, want.read_value,
                        rsp_data.read_value, want.length, rsp_data.length,
                        want.full_res, rsp_data.full_res);
               end
            end
         end
         if (req_valid && !req_stall) begin
            model_out = list_apply(req_data);
            hint = fixed_results.pop_front();
            list_results_due.push_back(hint.known ? hint.result : model_out);
         end
         if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR)
            cap_value = pwdata[pidl_pkg::CAP_W-1:0];
      end
   end

   // Stall the result channel in random bursts
   always @(posedge clock) begin
      if (calm) begin
         stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(7, 0) == 0) begin
         stall_left = $urandom_range(6, 1);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_request(pidl_pkg::req_item_type it, logic known,
                               pidl_pkg::rsp_item_type result);
      fixed_result_type hint;
      // idle the request channel now and then
      if (!calm && $urandom_range(5, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      hint.known = known;
      hint.result = result;
      fixed_results.push_back(hint);
      req_data  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off until every result has arrived, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (list_results_due.size() != 0 || fixed_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [pidl_pkg::CAP_W-1:0] v);
      logic [pidl_pkg::CSR_DATA_W-1:0] word;
      wait_idle();
      word = $urandom();
      word[pidl_pkg::CAP_W-1:0] = v;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CAPACITY_ADDR;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      script_row_type row;
      int cap;
      // empty list at reset capacity
      add_known(pidl_pkg::REQ_READ,   0,   32'd0, pidl_pkg::ST_RANGE, 32'd0, 0, 1'b0);
      add_known(pidl_pkg::REQ_REMOVE, 0,   32'd0, pidl_pkg::ST_RANGE, 32'd0, 0, 1'b0);
      add_known(pidl_pkg::REQ_INSERT, 1,   32'd5, pidl_pkg::ST_RANGE, 32'd0, 0, 1'b0);
      add_known(pidl_pkg::REQ_INSERT, 0,   32'h8000_0000, pidl_pkg::ST_DONE, 32'd0, 1, 1'b0);
      add_known(pidl_pkg::REQ_APPEND, 127, 32'h7FFF_FFFF, pidl_pkg::ST_DONE, 32'd0, 2, 1'b0);
      add_item(pidl_pkg::REQ_INSERT, 1, 32'hFFFF_FFFF);
      add_known(pidl_pkg::REQ_READ,   0,   32'd0, pidl_pkg::ST_DONE, 32'h8000_0000, 3, 1'b0);
      add_known(pidl_pkg::REQ_READ,   2,   32'd0, pidl_pkg::ST_DONE, 32'h7FFF_FFFF, 3, 1'b0);
      add_known(pidl_pkg::REQ_READ,   127, 32'd0, pidl_pkg::ST_RANGE, 32'd0, 3, 1'b0);
      add_known(pidl_pkg::REQ_REMOVE, 3,   32'd0, pidl_pkg::ST_RANGE, 32'd0, 3, 1'b0);
      add_known(pidl_pkg::REQ_INSERT, 127, 32'd7, pidl_pkg::ST_RANGE, 32'd0, 3, 1'b0);
      add_item(pidl_pkg::REQ_REMOVE, 1, 32'd0);
      add_item(pidl_pkg::REQ_READ,   1, 32'd0);
      add_item(pidl_pkg::REQ_INSERT, 2, 32'h5555_5555);
      add_item(pidl_pkg::REQ_REMOVE, 0, 32'd0);
      // zero capacity: always full, full wins over out of range
      add_capacity(0);
      add_known(pidl_pkg::REQ_APPEND, 0,   32'd1, pidl_pkg::ST_FULL, 32'd0, 2, 1'b1);
      add_known(pidl_pkg::REQ_INSERT, 127, 32'd1, pidl_pkg::ST_FULL, 32'd0, 2, 1'b1);
      add_item(pidl_pkg::REQ_READ, 1, 32'd0);
      // capacity lowered below the length keeps the entries
      add_capacity(1);
      add_known(pidl_pkg::REQ_INSERT, 0, 32'd3, pidl_pkg::ST_FULL, 32'd0, 2, 1'b1);
      add_known(pidl_pkg::REQ_REMOVE, 1, 32'd0, pidl_pkg::ST_DONE, 32'd0, 1, 1'b1);
      add_known(pidl_pkg::REQ_REMOVE, 0, 32'd0, pidl_pkg::ST_DONE, 32'd0, 0, 1'b0);
      add_known(pidl_pkg::REQ_APPEND, 0, 32'h2AAA_AAAA, pidl_pkg::ST_DONE, 32'd0, 1, 1'b1);
      // capacity beyond the store saturates
      add_capacity(127);
      add_item(pidl_pkg::REQ_APPEND, 0, 32'hD555_5555);
      add_item(pidl_pkg::REQ_READ,   0, 32'd0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[k]) begin
         row = script[k];
         if (row.kind == ROW_CAPACITY) write_capacity(row.capacity);
         else send_request(row.item, row.known, row.result);
      end

      // random phases, each under its own capacity; the last one without idling
      for (int p = 0; p < PHASES; p++) begin
         cap = (phase_cap[p] == ANY_CAP) ? $urandom_range(127, 0) : phase_cap[p];
         write_capacity(pidl_pkg::CAP_W'(cap));
         calm = (p == PHASES - 1);
         repeat (phase_len[p]) send_request(pick_request(phase_mix[p]), 1'b0, '0);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

endmodule
